// ----- rtl/rcrl_pkg.sv -----
`default_nettype none
package rcrl_pkg;

    localparam int CUR_W = 64;
    localparam int CAP_W = 63;
    localparam int DEP_W = 4;
    localparam int LOG_W = 6;

    localparam logic [CUR_W-1:0] LIMIT_STEP = 64'h1000_0000_0000_0000;
    localparam logic [LOG_W-1:0] LOG2_RESET = 6'd10;
    localparam logic [LOG_W-1:0] LOG2_SAT   = 6'd63;

    localparam logic [1:0] CMD_SET_CURSOR = 2'd0;
    localparam logic [1:0] CMD_SET_DEPS   = 2'd1;
    localparam logic [1:0] CMD_UPDATE     = 2'd2;

    typedef struct packed {
        logic [CUR_W-1:0] cursor;
        logic [CUR_W-1:0] limit;
        logic [DEP_W-1:0] dep_first;
        logic [DEP_W-1:0] dep_end;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_OWN  = 4'b0010,
        S_WALK = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

endpackage
`default_nettype wire

// ----- rtl/rcrl_ram.sv -----
`default_nettype none
module rcrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                             i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                             o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/ring_consumer_read_limit_unit.sv -----
`default_nettype none
// A set command or an update with an empty dependency range strobes its result
// once the consumer's own entry has been read; an update that walks k entries
// (k <= N_CONSUMERS) first reads them one at a time through the single RAM read port.
// One request at a time: busy stays high until the result is issued.
// Synchronous active-low reset clears control and marks all table entries as zero.
module ring_consumer_read_limit_unit #(
    parameter int N_CONSUMERS = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  i_command,
    input  wire logic [2:0]                  i_consumer_index,
    input  wire logic [rcrl_pkg::CUR_W-1:0]  i_cursor_value,
    input  wire logic [rcrl_pkg::DEP_W-1:0]  i_dep_first,
    input  wire logic [rcrl_pkg::DEP_W-1:0]  i_dep_end,
    input  wire logic                        i_cfg_we,
    input  wire logic [rcrl_pkg::LOG_W-1:0]  i_cfg_wdata,
    output logic                             o_valid,
    output logic [rcrl_pkg::CAP_W-1:0]       o_capacity,
    output logic [rcrl_pkg::CUR_W-1:0]       o_new_limit
);
    localparam int AW = (N_CONSUMERS > 1) ? $clog2(N_CONSUMERS) : 1;
    localparam int CW = $clog2(N_CONSUMERS + 1);
    localparam int XW = (CW > rcrl_pkg::DEP_W) ? CW : rcrl_pkg::DEP_W;
    localparam logic [XW-1:0] N_X = XW'(N_CONSUMERS);

    rcrl_pkg::t_state r_state, n_state;

    logic                           r_valid, n_valid;
    logic [rcrl_pkg::CAP_W-1:0]     r_cap, n_cap;
    logic [rcrl_pkg::CUR_W-1:0]     r_rlim, n_rlim;
    logic [rcrl_pkg::LOG_W-1:0]     r_log2;
    logic [N_CONSUMERS-1:0]         r_vld;
    logic                           r_rd_vld;

    logic [1:0]                     r_cmd;
    logic [AW-1:0]                  r_ci;
    logic                           r_ci_ok;
    logic [rcrl_pkg::CUR_W-1:0]     r_cur_in;
    logic [rcrl_pkg::DEP_W-1:0]     r_dfirst_in, r_dend_in;
    rcrl_pkg::t_entry               r_own, n_own;
    logic [rcrl_pkg::CUR_W-1:0]     r_lim, n_lim;
    logic [XW-1:0]                  r_i, n_i;
    logic [XW-1:0]                  r_first, n_first;

    logic                           w_accept;
    logic [AW-1:0]                  w_raddr;
    logic                           w_we;
    rcrl_pkg::t_entry               w_wdata;
    logic [rcrl_pkg::ENTRY_W-1:0]   w_rdata;
    rcrl_pkg::t_entry               w_ent;

    logic [rcrl_pkg::CUR_W-1:0]     w_base;
    logic [XW-1:0]                  w_endc;
    logic [rcrl_pkg::CAP_W-1:0]     w_ring_cap;
    logic [XW-1:0]                  w_skip, w_inext;
    logic [rcrl_pkg::CUR_W-1:0]     w_cdiff, w_limnext, w_fdiff;

    assign busy     = (r_state != rcrl_pkg::S_IDLE);
    assign w_accept = start && !busy;

    assign o_valid      = r_valid;
    assign o_capacity   = r_cap;
    assign o_new_limit  = r_rlim;

    rcrl_ram #(
        .WIDTH (rcrl_pkg::ENTRY_W),
        .DEPTH (N_CONSUMERS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_ci),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // entries never written read as zero
    assign w_ent = r_rd_vld ? rcrl_pkg::t_entry'(w_rdata) : '0;

    always_comb begin
        w_base     = w_ent.limit + rcrl_pkg::LIMIT_STEP;
        w_endc     = (XW'(w_ent.dep_end) > N_X) ? N_X : XW'(w_ent.dep_end);
        w_ring_cap = (r_log2 == rcrl_pkg::LOG2_SAT) ? '1
                                                    : (rcrl_pkg::CAP_W'(1) << r_log2);
        // walk step: entry r_i is on the read data
        w_skip    = (XW'(w_ent.dep_end) >= r_i) ? XW'(w_ent.dep_first) : r_i;
        w_inext   = (w_skip < r_i) ? w_skip : r_i;
        w_cdiff   = w_ent.cursor - r_lim;
        w_limnext = w_cdiff[rcrl_pkg::CUR_W-1] ? w_ent.cursor : r_lim;
        w_fdiff   = r_lim - r_own.cursor;
    end

    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        n_cap   = '0;
        n_rlim  = '0;
        n_own   = r_own;
        n_lim   = r_lim;
        n_i     = r_i;
        n_first = r_first;
        w_raddr = '0;
        w_we    = 1'b0;
        w_wdata = r_own;

        unique case (r_state)
            rcrl_pkg::S_IDLE: begin
                w_raddr = AW'(i_consumer_index);
                if (w_accept) begin
                    n_state = rcrl_pkg::S_OWN;
                end
            end
            rcrl_pkg::S_OWN: begin
                n_own   = w_ent;
                n_state = rcrl_pkg::S_IDLE;
                n_valid = 1'b1;
                if (r_ci_ok) begin
                    unique case (r_cmd)
                        rcrl_pkg::CMD_SET_CURSOR: begin
                            w_we           = 1'b1;
                            w_wdata        = w_ent;
                            w_wdata.cursor = r_cur_in;
                        end
                        rcrl_pkg::CMD_SET_DEPS: begin
                            w_we              = 1'b1;
                            w_wdata           = w_ent;
                            w_wdata.dep_first = r_dfirst_in;
                            w_wdata.dep_end   = r_dend_in;
                        end
                        rcrl_pkg::CMD_UPDATE: begin
                            n_lim   = w_base;
                            n_first = XW'(w_ent.dep_first);
                            if (XW'(w_ent.dep_first) >= w_endc) begin
                                w_we          = 1'b1;
                                w_wdata       = w_ent;
                                w_wdata.limit = w_base;
                                n_cap         = w_ring_cap;
                                n_rlim        = w_base;
                            end else begin
                                n_valid = 1'b0;
                                n_i     = w_endc - XW'(1);
                                w_raddr = AW'(w_endc - XW'(1));
                                n_state = rcrl_pkg::S_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            rcrl_pkg::S_WALK: begin
                n_lim = w_limnext;
                if (w_inext > r_first) begin
                    n_i     = w_inext - XW'(1);
                    w_raddr = AW'(w_inext - XW'(1));
                end else begin
                    n_state = rcrl_pkg::S_FIN;
                end
            end
            rcrl_pkg::S_FIN: begin
                w_we          = 1'b1;
                w_wdata       = r_own;
                w_wdata.limit = r_lim;
                n_valid       = 1'b1;
                n_rlim        = r_lim;
                // positive signed difference only
                if (!w_fdiff[rcrl_pkg::CUR_W-1] && (w_fdiff != '0)) begin
                    n_cap = w_fdiff[rcrl_pkg::CAP_W-1:0];
                end
                n_state = rcrl_pkg::S_IDLE;
            end
            default: begin
                n_state = rcrl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rcrl_pkg::S_IDLE;
            r_valid  <= 1'b0;
            r_log2   <= rcrl_pkg::LOG2_RESET;
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_rd_vld <= r_vld[w_raddr];
            if (i_cfg_we) begin
                r_log2 <= i_cfg_wdata;
            end
            if (w_we) begin
                r_vld[r_ci] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cap   <= n_cap;
        r_rlim  <= n_rlim;
        r_own   <= n_own;
        r_lim   <= n_lim;
        r_i     <= n_i;
        r_first <= n_first;
        if (w_accept) begin
            r_cmd       <= i_command;
            r_ci        <= AW'(i_consumer_index);
            r_ci_ok     <= (XW'(i_consumer_index) < N_X);
            r_cur_in    <= i_cursor_value;
            r_dfirst_in <= i_dep_first;
            r_dend_in   <= i_dep_end;
        end
    end
endmodule
`default_nettype wire
